>>> design/ibal_pkg.sv
package ibal_pkg;

    // command codes on the cmd field
    localparam logic [1:0] CMD_SET_LOAD  = 2'd0;
    localparam logic [1:0] CMD_SET_STATS = 2'd1;
    localparam logic [1:0] CMD_BALANCE   = 2'd2;
    localparam logic [1:0] CMD_PLACE     = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_STRATEGY  = 2'd1;
    localparam logic [1:0] CFG_SEED      = 2'd2;

    // pick rules
    localparam logic [1:0] STRAT_MAX  = 2'd0;
    localparam logic [1:0] STRAT_MIN  = 2'd1;
    localparam logic [1:0] STRAT_RAND = 2'd2;

    localparam logic [13:0] RESET_THRESHOLD = 14'd9000;
    localparam logic [15:0] RESET_SEED      = 16'd44257;

    // candidate counts are held in nine bits, up to 511
    localparam int CAND_W = 9;

    typedef struct packed {
        logic [31:0] intr;
        logic [7:0]  mask;
        logic [7:0]  weight;
        logic [2:0]  owner;
    } ibal_ent_t;

    localparam int ENT_W = $bits(ibal_ent_t);

    typedef struct packed {
        logic              start;
        logic [15:0]       dividend;
        logic [CAND_W-1:0] divisor;
    } ibal_rem_req_t;

    typedef struct packed {
        logic              done;
        logic [CAND_W-1:0] rem;
    } ibal_rem_resp_t;

endpackage

>>> design/ibal_ram.sv
module ibal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/ibal_rem.sv
module ibal_rem
    import ibal_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  ibal_rem_req_t  req,
    output ibal_rem_resp_t resp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [4:0]        n_reg, n_next;
    logic [15:0]       dvd_reg, dvd_next;
    logic [CAND_W-1:0] r_reg, r_next;
    logic [CAND_W-1:0] div_reg, div_next;
    logic [CAND_W:0]   r2;

    // one restoring step a cycle, sixteen steps
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        n_next    = n_reg;
        dvd_next  = dvd_reg;
        r_next    = r_reg;
        div_next  = div_reg;
        r2        = {r_reg, dvd_reg[15]};
        if (req.start)
        begin
            busy_next = 1'b1;
            n_next    = 5'd16;
            dvd_next  = req.dividend;
            r_next    = '0;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (r2 >= {1'b0, div_reg})
            begin
                r_next = CAND_W'(r2 - {1'b0, div_reg});
            end
            else
            begin
                r_next = r2[CAND_W-1:0];
            end
            dvd_next = {dvd_reg[14:0], 1'b0};
            n_next   = n_reg - 5'd1;
            if (n_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            n_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            n_reg    <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        r_reg   <= r_next;
        div_reg <= div_next;
    end

    assign resp.done = done_reg;
    assign resp.rem  = r_reg;

endmodule

>>> design/irq_affinity_balancer.sv
// channel | direction | handshake            | word
// in      | input     | in_valid / in_ready  | cmd, cpu_index, cpu_load, irq_index,
//         |           |                      | irq_intr_count, irq_local_mask
// out     | output    | out_valid / out_ready| moved, moved_irq, had_owner, old_cpu, new_cpu
// cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// A balance step walks the IRQ table once to count owners, then up to twice per CPU
// (minimum weight search and aging), then up to three more times for pick, random
// select and move aging; each walk reads through the single read port of the IRQ
// table. Reset clears loads, owners, stats and loads the LFSR with the seed; no
// clearing pass is needed. The input takes a word only when the sequencer is idle;
// a result waiting on out_ready holds the sequencer at its end.
module irq_affinity_balancer
    import ibal_pkg::*;
#(
    parameter int NUM_CPUS = 8,
    parameter int NUM_IRQS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [2:0]  cpu_index,
    input  logic [13:0] cpu_load,
    input  logic [5:0]  irq_index,
    input  logic [31:0] irq_intr_count,
    input  logic [7:0]  irq_local_mask,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        moved,
    output logic [5:0]  moved_irq,
    output logic        had_owner,
    output logic [2:0]  old_cpu,
    output logic [2:0]  new_cpu,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IW     = $clog2(NUM_IRQS);
    localparam int CW     = $clog2(NUM_CPUS);
    localparam int CCW    = (CW + 1 > 3) ? CW + 1 : 3;
    localparam int TGT_N  = (NUM_CPUS < 8) ? NUM_CPUS : 8;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_C1RD  = 4'd1;
    localparam logic [3:0] S_C1WR  = 4'd2;
    localparam logic [3:0] S_CNT   = 4'd3;
    localparam logic [3:0] S_BSEL  = 4'd4;
    localparam logic [3:0] S_BSCAN = 4'd5;
    localparam logic [3:0] S_BAGE  = 4'd6;
    localparam logic [3:0] S_PSCAN = 4'd7;
    localparam logic [3:0] S_PDIV  = 4'd8;
    localparam logic [3:0] S_PFIND = 4'd9;
    localparam logic [3:0] S_PRD   = 4'd10;
    localparam logic [3:0] S_PRD2  = 4'd11;
    localparam logic [3:0] S_PTGT  = 4'd12;
    localparam logic [3:0] S_MAGE  = 4'd13;
    localparam logic [3:0] S_PWR   = 4'd14;
    localparam logic [3:0] S_FIN   = 4'd15;

    logic [3:0]        state_reg, state_next;
    logic              is_bal_reg, is_bal_next;
    logic [13:0]       thr_reg, thr_next;
    logic [1:0]        strat_reg, strat_next;
    logic [15:0]       lfsr_reg, lfsr_next;
    logic [13:0]       load_reg [NUM_CPUS];
    logic [13:0]       load_next [NUM_CPUS];
    logic [IW:0]       cnt_reg [8];
    logic [IW:0]       cnt_next [8];
    logic [NUM_IRQS-1:0] written_reg, written_next;
    logic [NUM_IRQS-1:0] ovalid_reg, ovalid_next;
    logic [IW:0]       rp_reg, rp_next;
    logic              dv_reg, dv_next;
    logic [IW-1:0]     da_reg, da_next;
    logic [CCW-1:0]    c_reg, c_next;
    logic [13:0]       maxl_reg, maxl_next;
    logic [CCW-1:0]    over_reg, over_next;
    logic              of_reg, of_next;
    logic              nf_reg, nf_next;
    logic [7:0]        minw_reg, minw_next;
    logic              pf_reg, pf_next;
    logic [IW-1:0]     pick_reg, pick_next;
    logic [31:0]       best_reg, best_next;
    logic [CAND_W-1:0] cand_reg, cand_next;
    logic [CAND_W-1:0] choose_reg, choose_next;
    logic [CAND_W-1:0] cur_reg, cur_next;
    logic [31:0]       pk_intr_reg, pk_intr_next;
    logic [7:0]        pk_mask_reg, pk_mask_next;
    logic [7:0]        pk_w_reg, pk_w_next;
    logic              pk_had_reg, pk_had_next;
    logic [2:0]        pk_old_reg, pk_old_next;
    logic [2:0]        t_reg, t_next;
    logic              tf_reg, tf_next;
    logic [13:0]       tload_reg, tload_next;
    logic [IW:0]       tn_reg, tn_next;
    logic              mv_reg, mv_next;
    logic              ov_reg, ov_next;
    logic              o_moved_reg, o_moved_next;
    logic [5:0]        o_irq_reg, o_irq_next;
    logic              o_had_reg, o_had_next;
    logic [2:0]        o_old_reg, o_old_next;
    logic [2:0]        o_new_reg, o_new_next;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [IW-1:0]     ram_raddr;
    ibal_ent_t         ram_wdata;
    logic [ENT_W-1:0]  ram_rdata;
    ibal_ent_t         ent;

    ibal_rem_req_t     rem_req;
    ibal_rem_resp_t    rem_resp;

    logic              scan_st;
    logic              issue;
    logic              scan_done;
    logic              own_c;
    logic              own_over;
    logic              cand_hit;
    logic [13:0]       ld_c;
    logic [IW:0]       cnt_c;
    logic [15:0]       lfsr_adv;
    logic              accept;
    logic [7:0]        w_new;

    ibal_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_IRQS)
    ) u_tab (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ibal_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .resp  (rem_resp)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign moved     = o_moved_reg;
    assign moved_irq = o_irq_reg;
    assign had_owner = o_had_reg;
    assign old_cpu   = o_old_reg;
    assign new_cpu   = o_new_reg;

    // entries never written read as zero
    assign ent = written_reg[da_reg] ? ibal_ent_t'(ram_rdata) : '0;

    assign scan_st = (state_reg == S_CNT) || (state_reg == S_BSCAN) ||
                     (state_reg == S_BAGE) || (state_reg == S_PSCAN) ||
                     (state_reg == S_PFIND) || (state_reg == S_MAGE);
    assign issue     = scan_st && (rp_reg < (IW+1)'(NUM_IRQS));
    assign scan_done = scan_st && (rp_reg == (IW+1)'(NUM_IRQS)) && !dv_reg;

    assign own_c    = ovalid_reg[da_reg] && (CCW'(ent.owner) == c_reg);
    assign own_over = ovalid_reg[da_reg] && (CCW'(ent.owner) == over_reg);
    assign cand_hit = dv_reg && own_over && (ent.intr != 32'd0) && (ent.weight == 8'd0);
    assign ld_c     = load_reg[c_reg[CW-1:0]];
    assign cnt_c    = (c_reg < CCW'(8)) ? cnt_reg[c_reg[2:0]] : '0;
    assign lfsr_adv = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5], lfsr_reg[15:1]};

    assign rem_req.start    = (state_reg == S_PSCAN) && scan_done &&
                              (strat_reg == STRAT_RAND) && (cand_reg != '0);
    assign rem_req.dividend = lfsr_adv;
    assign rem_req.divisor  = cand_reg;

    always_comb
    begin
        state_next   = state_reg;
        is_bal_next  = is_bal_reg;
        thr_next     = thr_reg;
        strat_next   = strat_reg;
        lfsr_next    = lfsr_reg;
        load_next    = load_reg;
        cnt_next     = cnt_reg;
        written_next = written_reg;
        ovalid_next  = ovalid_reg;
        rp_next      = issue ? rp_reg + 1'b1 : rp_reg;
        dv_next      = issue;
        da_next      = issue ? rp_reg[IW-1:0] : da_reg;
        c_next       = c_reg;
        maxl_next    = maxl_reg;
        over_next    = over_reg;
        of_next      = of_reg;
        nf_next      = nf_reg;
        minw_next    = minw_reg;
        pf_next      = pf_reg;
        pick_next    = pick_reg;
        best_next    = best_reg;
        cand_next    = cand_reg;
        choose_next  = choose_reg;
        cur_next     = cur_reg;
        pk_intr_next = pk_intr_reg;
        pk_mask_next = pk_mask_reg;
        pk_w_next    = pk_w_reg;
        pk_had_next  = pk_had_reg;
        pk_old_next  = pk_old_reg;
        t_next       = t_reg;
        tf_next      = tf_reg;
        tload_next   = tload_reg;
        tn_next      = tn_reg;
        mv_next      = mv_reg;
        ov_next      = ov_reg;
        o_moved_next = o_moved_reg;
        o_irq_next   = o_irq_reg;
        o_had_next   = o_had_reg;
        o_old_next   = o_old_reg;
        o_new_next   = o_new_reg;
        ram_we       = 1'b0;
        ram_waddr    = da_reg;
        ram_wdata    = ent;
        ram_raddr    = rp_reg[IW-1:0];
        w_new        = ent.weight;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: thr_next = cfg_data[13:0];
                CFG_STRATEGY:  strat_next = cfg_data[1:0];
                CFG_SEED:      lfsr_next = cfg_data;
                default:       ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                rp_next = '0;
                if (accept)
                begin
                    for (int k = 0; k < 8; k++)
                    begin
                        cnt_next[k] = '0;
                    end
                    is_bal_next = (cmd == CMD_BALANCE);
                    mv_next     = 1'b0;
                    pf_next     = 1'b0;
                    of_next     = 1'b0;
                    tf_next     = 1'b0;
                    maxl_next   = '0;
                    c_next      = '0;
                    cand_next   = '0;
                    cur_next    = '0;
                    pick_next   = IW'(irq_index);
                    pk_intr_next = irq_intr_count;
                    pk_mask_next = irq_local_mask;
                    state_next  = S_FIN;
                    unique case (cmd)
                        CMD_SET_LOAD:
                        begin
                            if (32'(cpu_index) < NUM_CPUS)
                            begin
                                load_next[CW'(cpu_index)] = cpu_load;
                            end
                        end
                        CMD_SET_STATS:
                        begin
                            if (32'(irq_index) < NUM_IRQS)
                            begin
                                state_next = S_C1RD;
                            end
                        end
                        CMD_BALANCE:
                        begin
                            state_next = S_CNT;
                        end
                        CMD_PLACE:
                        begin
                            if (32'(irq_index) < NUM_IRQS)
                            begin
                                state_next = S_CNT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_C1RD:
            begin
                ram_raddr  = pick_reg;
                da_next    = pick_reg;
                state_next = S_C1WR;
            end
            S_C1WR:
            begin
                // keep owner and weight
                ram_we       = 1'b1;
                ram_waddr    = pick_reg;
                ram_wdata    = ent;
                ram_wdata.intr = pk_intr_reg;
                ram_wdata.mask = pk_mask_reg;
                written_next[pick_reg] = 1'b1;
                state_next   = S_FIN;
            end
            S_CNT:
            begin
                if (dv_reg && ovalid_reg[da_reg])
                begin
                    cnt_next[ent.owner] = cnt_reg[ent.owner] + 1'b1;
                end
                if (scan_done)
                begin
                    rp_next    = '0;
                    state_next = is_bal_reg ? S_BSEL : S_PRD;
                end
            end
            S_BSEL:
            begin
                if (c_reg == CCW'(NUM_CPUS))
                begin
                    if (!of_reg || (strat_reg != STRAT_MAX && strat_reg != STRAT_MIN &&
                                    strat_reg != STRAT_RAND))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_PSCAN;
                    end
                end
                else if (ld_c >= thr_reg && ld_c > maxl_reg && cnt_c > (IW+1)'(1))
                begin
                    nf_next    = 1'b0;
                    minw_next  = '0;
                    state_next = S_BSCAN;
                end
                else
                begin
                    c_next = c_reg + 1'b1;
                end
            end
            S_BSCAN:
            begin
                if (dv_reg && own_c && ent.intr != 32'd0)
                begin
                    if (!nf_reg || ent.weight < minw_reg)
                    begin
                        minw_next = ent.weight;
                    end
                    nf_next = 1'b1;
                end
                if (scan_done)
                begin
                    rp_next = '0;
                    if (!nf_reg)
                    begin
                        c_next     = c_reg + 1'b1;
                        state_next = S_BSEL;
                    end
                    else if (minw_reg != 8'd0)
                    begin
                        state_next = S_BAGE;
                    end
                    else
                    begin
                        maxl_next  = ld_c;
                        over_next  = c_reg;
                        of_next    = 1'b1;
                        c_next     = c_reg + 1'b1;
                        state_next = S_BSEL;
                    end
                end
            end
            S_BAGE:
            begin
                if (dv_reg && own_c && ent.weight >= minw_reg)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ent;
                    ram_wdata.weight = ent.weight - minw_reg;
                end
                if (scan_done)
                begin
                    rp_next    = '0;
                    maxl_next  = ld_c;
                    over_next  = c_reg;
                    of_next    = 1'b1;
                    c_next     = c_reg + 1'b1;
                    state_next = S_BSEL;
                end
            end
            S_PSCAN:
            begin
                if (cand_hit)
                begin
                    if (strat_reg == STRAT_RAND)
                    begin
                        cand_next = cand_reg + 1'b1;
                    end
                    else if (!pf_reg ||
                             (strat_reg == STRAT_MAX && ent.intr > best_reg) ||
                             (strat_reg == STRAT_MIN && ent.intr < best_reg))
                    begin
                        pf_next   = 1'b1;
                        pick_next = da_reg;
                        best_next = ent.intr;
                    end
                end
                if (scan_done)
                begin
                    rp_next = '0;
                    if (strat_reg == STRAT_RAND)
                    begin
                        if (cand_reg == '0)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            lfsr_next  = lfsr_adv;
                            state_next = S_PDIV;
                        end
                    end
                    else
                    begin
                        state_next = pf_reg ? S_PRD : S_FIN;
                    end
                end
            end
            S_PDIV:
            begin
                if (rem_resp.done)
                begin
                    choose_next = rem_resp.rem;
                    state_next  = S_PFIND;
                end
            end
            S_PFIND:
            begin
                if (cand_hit && !pf_reg)
                begin
                    if (cur_reg == choose_reg)
                    begin
                        pf_next   = 1'b1;
                        pick_next = da_reg;
                    end
                    else
                    begin
                        cur_next = cur_reg + 1'b1;
                    end
                end
                if (scan_done)
                begin
                    rp_next    = '0;
                    state_next = S_PRD;
                end
            end
            S_PRD:
            begin
                ram_raddr  = pick_reg;
                da_next    = pick_reg;
                state_next = S_PRD2;
            end
            S_PRD2:
            begin
                pk_intr_next = ent.intr;
                pk_mask_next = ent.mask;
                pk_w_next    = is_bal_reg ? 8'd1 : ent.weight;
                pk_had_next  = ovalid_reg[pick_reg];
                pk_old_next  = ent.owner;
                c_next       = '0;
                tf_next      = 1'b0;
                state_next   = S_PTGT;
            end
            S_PTGT:
            begin
                if (c_reg == CCW'(TGT_N))
                begin
                    if (tf_reg)
                    begin
                        state_next = S_MAGE;
                    end
                    else
                    begin
                        state_next = is_bal_reg ? S_PWR : S_FIN;
                    end
                end
                else
                begin
                    if (pk_mask_reg[c_reg[2:0]] && ld_c < thr_reg &&
                        (!tf_reg || ld_c < tload_reg || (ld_c == tload_reg && cnt_c < tn_reg)))
                    begin
                        tf_next    = 1'b1;
                        t_next     = c_reg[2:0];
                        tload_next = ld_c;
                        tn_next    = cnt_c;
                    end
                    c_next = c_reg + 1'b1;
                end
            end
            S_MAGE:
            begin
                // old owner loses one, then the new owner loses one
                if (dv_reg && da_reg != pick_reg && ovalid_reg[da_reg] &&
                    ((pk_had_reg && ent.owner == pk_old_reg) || ent.owner == t_reg))
                begin
                    if (pk_had_reg && ent.owner == pk_old_reg && w_new != 8'd0)
                    begin
                        w_new = w_new - 8'd1;
                    end
                    if (ent.owner == t_reg && w_new != 8'd0)
                    begin
                        w_new = w_new - 8'd1;
                    end
                    ram_we    = 1'b1;
                    ram_wdata = ent;
                    ram_wdata.weight = w_new;
                end
                if (scan_done)
                begin
                    rp_next    = '0;
                    state_next = S_PWR;
                end
            end
            S_PWR:
            begin
                ram_we           = 1'b1;
                ram_waddr        = pick_reg;
                ram_wdata.intr   = pk_intr_reg;
                ram_wdata.mask   = pk_mask_reg;
                ram_wdata.weight = pk_w_reg;
                ram_wdata.owner  = tf_reg ? t_reg : pk_old_reg;
                written_next[pick_reg] = 1'b1;
                if (tf_reg)
                begin
                    ovalid_next[pick_reg] = 1'b1;
                end
                mv_next    = tf_reg;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next      = 1'b1;
                    o_moved_next = mv_reg;
                    o_irq_next   = mv_reg ? 6'(pick_reg) : 6'd0;
                    o_had_next   = mv_reg && pk_had_reg;
                    o_old_next   = (mv_reg && pk_had_reg) ? pk_old_reg : 3'd0;
                    o_new_next   = mv_reg ? t_reg : 3'd0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            is_bal_reg  <= 1'b0;
            thr_reg     <= RESET_THRESHOLD;
            strat_reg   <= STRAT_MAX;
            lfsr_reg    <= RESET_SEED;
            for (int k = 0; k < NUM_CPUS; k++)
            begin
                load_reg[k] <= '0;
            end
            for (int k = 0; k < 8; k++)
            begin
                cnt_reg[k] <= '0;
            end
            written_reg <= '0;
            ovalid_reg  <= '0;
            rp_reg      <= '0;
            dv_reg      <= 1'b0;
            c_reg       <= '0;
            of_reg      <= 1'b0;
            nf_reg      <= 1'b0;
            pf_reg      <= 1'b0;
            tf_reg      <= 1'b0;
            mv_reg      <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            is_bal_reg  <= is_bal_next;
            thr_reg     <= thr_next;
            strat_reg   <= strat_next;
            lfsr_reg    <= lfsr_next;
            load_reg    <= load_next;
            cnt_reg     <= cnt_next;
            written_reg <= written_next;
            ovalid_reg  <= ovalid_next;
            rp_reg      <= rp_next;
            dv_reg      <= dv_next;
            c_reg       <= c_next;
            of_reg      <= of_next;
            nf_reg      <= nf_next;
            pf_reg      <= pf_next;
            tf_reg      <= tf_next;
            mv_reg      <= mv_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        da_reg      <= da_next;
        maxl_reg    <= maxl_next;
        over_reg    <= over_next;
        minw_reg    <= minw_next;
        pick_reg    <= pick_next;
        best_reg    <= best_next;
        cand_reg    <= cand_next;
        choose_reg  <= choose_next;
        cur_reg     <= cur_next;
        pk_intr_reg <= pk_intr_next;
        pk_mask_reg <= pk_mask_next;
        pk_w_reg    <= pk_w_next;
        pk_had_reg  <= pk_had_next;
        pk_old_reg  <= pk_old_next;
        t_reg       <= t_next;
        tload_reg   <= tload_next;
        tn_reg      <= tn_next;
        o_moved_reg <= o_moved_next;
        o_irq_reg   <= o_irq_next;
        o_had_reg   <= o_had_next;
        o_old_reg   <= o_old_next;
        o_new_reg   <= o_new_next;
    end

    a_no_move_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !moved |-> moved_irq == 6'd0 && new_cpu == 3'd0 && !had_owner)
        else $error("result without move carries nonzero fields");

    a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && moved |-> 32'(new_cpu) < NUM_CPUS)
        else $error("move target outside CPU range");

    a_rem_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        rem_resp.done |-> state_reg == S_PDIV)
        else $error("remainder finished outside the random pick");

endmodule

>>> dv/testbench.sv
module testbench;
    import ibal_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCPU = 8;
    localparam int NIRQ = 64;
    localparam int TARGET_ITEMS = 1700;
    localparam longint CYCLE_LIMIT = 6000000;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  cpu;
        logic [13:0] load;
        logic [5:0]  irq;
        logic [31:0] cnt;
        logic [7:0]  mask;
    } cmd_word_t;

    typedef struct packed {
        logic       moved;
        logic [5:0] irq;
        logic       had;
        logic [2:0] old_c;
        logic [2:0] new_c;
    } move_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [2:0]  cpu_index;
    logic [13:0] cpu_load;
    logic [5:0]  irq_index;
    logic [31:0] irq_intr_count;
    logic [7:0]  irq_local_mask;
    logic        out_valid;
    logic        out_ready;
    logic        moved;
    logic [5:0]  moved_irq;
    logic        had_owner;
    logic [2:0]  old_cpu;
    logic [2:0]  new_cpu;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    irq_affinity_balancer i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .cpu_index      (cpu_index),
        .cpu_load       (cpu_load),
        .irq_index      (irq_index),
        .irq_intr_count (irq_intr_count),
        .irq_local_mask (irq_local_mask),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .moved          (moved),
        .moved_irq      (moved_irq),
        .had_owner      (had_owner),
        .old_cpu        (old_cpu),
        .new_cpu        (new_cpu),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // balancer state as the testbench sees it
    logic [13:0] cpu_ld[NCPU];
    logic        own_v[NIRQ];
    logic [2:0]  own_c[NIRQ];
    logic [31:0] irq_cnt[NIRQ];
    logic [7:0]  irq_wt[NIRQ];
    logic [7:0]  irq_mask[NIRQ];
    logic [15:0] lfsr_q;
    logic [13:0] thr_q;
    logic [1:0]  strat_q;

    cmd_word_t pend_q[$];
    move_t     move_q[$];
    int        errors;
    int        n_items;
    int        n_moves;
    int        n_balance;
    longint    cycles;

    function automatic int owned_total(int c);
        int n;
        n = 0;
        for (int i = 0; i < NIRQ; i++)
            if (own_v[i] && own_c[i] == c)
                n++;
        return n;
    endfunction

    function automatic void age_weights(int c, int amt);
        for (int i = 0; i < NIRQ; i++)
            if (own_v[i] && own_c[i] == c && irq_wt[i] >= amt)
                irq_wt[i] = irq_wt[i] - amt;
    endfunction

    function automatic int least_loaded(logic [7:0] m);
        int best;
        int best_n;
        int n;
        best = -1;
        best_n = 0;
        for (int c = 0; c < NCPU; c++) begin
            if (!m[c] || cpu_ld[c] >= thr_q)
                continue;
            n = owned_total(c);
            if (best < 0 || cpu_ld[c] < cpu_ld[best] ||
                (cpu_ld[c] == cpu_ld[best] && n < best_n)) begin
                best = c;
                best_n = n;
            end
        end
        return best;
    endfunction

    function automatic move_t migrate(int irq, int c);
        move_t r;
        r = '0;
        r.had = own_v[irq];
        if (own_v[irq]) begin
            r.old_c = own_c[irq];
            own_v[irq] = 1'b0;
            age_weights(r.old_c, 1);
        end
        age_weights(c, 1);
        own_v[irq] = 1'b1;
        own_c[irq] = c;
        r.moved = 1'b1;
        r.irq = irq;
        r.new_c = c;
        return r;
    endfunction

    function automatic logic candidate(int i, int c);
        return own_v[i] && own_c[i] == c && irq_cnt[i] != 0 && irq_wt[i] == 0;
    endfunction

    function automatic move_t balance_once();
        move_t r;
        int unsigned top_ld;
        int hot;
        int n;
        int minw;
        int pick;
        int cand;
        int choose;
        int cur;
        int t;
        logic fb;
        r = '0;
        top_ld = 0;
        hot = -1;
        for (int c = 0; c < NCPU; c++) begin
            if (cpu_ld[c] < thr_q || cpu_ld[c] <= top_ld)
                continue;
            if (owned_total(c) <= 1)
                continue;
            n = 0;
            minw = 0;
            for (int i = 0; i < NIRQ; i++) begin
                if (!(own_v[i] && own_c[i] == c) || irq_cnt[i] == 0)
                    continue;
                if (n == 0 || irq_wt[i] < minw)
                    minw = irq_wt[i];
                n++;
            end
            if (n == 0)
                continue;
            if (minw > 0)
                age_weights(c, minw);
            top_ld = cpu_ld[c];
            hot = c;
        end
        if (hot < 0)
            return r;
        pick = -1;
        if (strat_q == STRAT_MAX || strat_q == STRAT_MIN) begin
            for (int i = 0; i < NIRQ; i++) begin
                if (!candidate(i, hot))
                    continue;
                if (pick < 0 ||
                    (strat_q == STRAT_MAX && irq_cnt[i] > irq_cnt[pick]) ||
                    (strat_q == STRAT_MIN && irq_cnt[i] < irq_cnt[pick]))
                    pick = i;
            end
        end else if (strat_q == STRAT_RAND) begin
            cand = 0;
            for (int i = 0; i < NIRQ; i++)
                if (candidate(i, hot))
                    cand++;
            if (cand == 0)
                return r;
            fb = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
            lfsr_q = {fb, lfsr_q[15:1]};
            choose = int'(lfsr_q) % cand;
            cur = 0;
            for (int i = 0; i < NIRQ; i++) begin
                if (!candidate(i, hot))
                    continue;
                if (cur == choose) begin
                    pick = i;
                    break;
                end
                cur++;
            end
        end
        if (pick < 0)
            return r;
        irq_wt[pick] = 1;
        t = least_loaded(irq_mask[pick]);
        if (t >= 0)
            r = migrate(pick, t);
        return r;
    endfunction

    function automatic move_t predict_move(cmd_word_t w);
        move_t r;
        int t;
        r = '0;
        case (w.op)
            CMD_SET_LOAD:  cpu_ld[w.cpu] = w.load;
            CMD_SET_STATS: begin
                irq_cnt[w.irq] = w.cnt;
                irq_mask[w.irq] = w.mask;
            end
            CMD_BALANCE:   r = balance_once();
            default: begin
                t = least_loaded(irq_mask[w.irq]);
                if (t >= 0)
                    r = migrate(w.irq, t);
            end
        endcase
        return r;
    endfunction

    // stimulus helpers; fields a command ignores carry random bits
    function automatic cmd_word_t noise_word();
        cmd_word_t w;
        w.op = $urandom_range(0, 3);
        w.cpu = $urandom;
        w.load = $urandom;
        w.irq = $urandom;
        w.cnt = $urandom;
        w.mask = $urandom;
        return w;
    endfunction

    task automatic add_load(int c, int ld);
        cmd_word_t w;
        w = noise_word();
        w.op = CMD_SET_LOAD;
        w.cpu = c;
        w.load = ld;
        pend_q.push_back(w);
    endtask

    task automatic add_stats(int i, logic [31:0] cnt, logic [7:0] m);
        cmd_word_t w;
        w = noise_word();
        w.op = CMD_SET_STATS;
        w.irq = i;
        w.cnt = cnt;
        w.mask = m;
        pend_q.push_back(w);
    endtask

    task automatic add_op(logic [1:0] op, int i);
        cmd_word_t w;
        w = noise_word();
        w.op = op;
        w.irq = i;
        pend_q.push_back(w);
    endtask

    function automatic logic [31:0] rand_count();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return $urandom_range(1, 20);
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // one well-formed sequence: spread IRQs, overload a few CPUs, balance
    task automatic scenario();
        int nirq;
        int i;
        int c;
        for (int k = 0; k < NCPU; k++)
            add_load(k, $urandom_range(0, 6000));
        nirq = $urandom_range(4, 16);
        for (int k = 0; k < nirq; k++) begin
            i = $urandom_range(0, NIRQ - 1);
            add_stats(i, rand_count(), ($urandom_range(0, 9) == 0) ? 8'hFF : $urandom);
            add_op(CMD_PLACE, i);
        end
        for (int k = $urandom_range(1, 3); k > 0; k--) begin
            c = $urandom_range(0, NCPU - 1);
            add_load(c, $urandom_range(int'(thr_q), 16383));
        end
        for (int k = $urandom_range(3, 10); k > 0; k--) begin
            case ($urandom_range(0, 9))
                0: pend_q.push_back(noise_word());
                1: add_stats($urandom_range(0, NIRQ - 1), rand_count(), $urandom);
                2: add_load($urandom_range(0, NCPU - 1), $urandom_range(0, 16383));
                default: add_op(CMD_BALANCE, 0);
            endcase
        end
    endtask

    task automatic drain();
        while (pend_q.size() != 0 || in_valid || move_q.size() != 0)
            @(posedge clk);
        // results come at the end of each step; the extra wait lets the sequencer settle
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_THRESHOLD: thr_q = val[13:0];
            CFG_STRATEGY:  strat_q = val[1:0];
            default:       lfsr_q = val;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sender: bursts of random length with random gaps
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd <= '0;
            cpu_index <= '0;
            cpu_load <= '0;
            irq_index <= '0;
            irq_intr_count <= '0;
            irq_local_mask <= '0;
            burst_left <= 4;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                move_q.push_back(predict_move({cmd, cpu_index, cpu_load, irq_index,
                                               irq_intr_count, irq_local_mask}));
                n_items++;
                if (cmd == CMD_BALANCE)
                    n_balance++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pend_q.size() != 0)
                begin
                    {cmd, cpu_index, cpu_load, irq_index, irq_intr_count,
                     irq_local_mask} <= pend_q.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall patterns; two long hold-offs
    int hold_left;
    int ready_mode;
    int long_holds;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            ready_mode <= 0;
            long_holds <= 0;
        end
        else
        begin
            if (cycles % 64 == 0)
                ready_mode <= $urandom_range(0, 3);
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (long_holds < 2 && n_moves > 0 && n_items > 300 + long_holds * 600)
            begin
                long_holds <= long_holds + 1;
                hold_left <= 3000;
                out_ready <= 1'b0;
            end
            else
                case (ready_mode)
                    0, 1: out_ready <= 1'b1;
                    2:    out_ready <= $urandom_range(0, 1);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
        end
    end

    // monitor and run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: errors");
            $finish;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (move_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word at cycle %0d", cycles);
            end
            else
            begin
                move_t e;
                e = move_q.pop_front();
                if (e.moved)
                    n_moves++;
                if (e != {moved, moved_irq, had_owner, old_cpu, new_cpu})
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch at cycle %0d: expected moved=%0d irq=%0d had=%0d old=%0d new=%0d, got moved=%0d irq=%0d had=%0d old=%0d new=%0d",
                                 cycles, e.moved, e.irq, e.had, e.old_c, e.new_c,
                                 moved, moved_irq, had_owner, old_cpu, new_cpu);
                end
            end
        end
    end

    initial
    begin
        logic [13:0] thr_set[8];
        logic [1:0]  strat_set[8];
        logic [15:0] seed_set[8];
        int phase;
        errors = 0;
        n_items = 0;
        n_moves = 0;
        n_balance = 0;
        cycles = 0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int c = 0; c < NCPU; c++)
            cpu_ld[c] = '0;
        for (int i = 0; i < NIRQ; i++)
        begin
            own_v[i] = 1'b0;
            own_c[i] = '0;
            irq_cnt[i] = '0;
            irq_wt[i] = '0;
            irq_mask[i] = '0;
        end
        thr_q = RESET_THRESHOLD;
        strat_q = STRAT_MAX;
        lfsr_q = RESET_SEED;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, every command, corner cases
        add_load(0, 0);
        add_load(7, 16383);
        add_stats(0, 32'hFFFF_FFFF, 8'hFF);
        add_stats(63, 32'd0, 8'h00);
        add_op(CMD_PLACE, 63);           // empty mask: no target
        add_op(CMD_PLACE, 0);
        add_op(CMD_PLACE, 0);            // again: equal load, the CPU with fewer IRQs wins
        add_stats(1, 32'd1, 8'h80);      // only target is an overloaded CPU
        add_op(CMD_PLACE, 1);
        add_stats(2, 32'd5, 8'h03);
        add_op(CMD_PLACE, 2);
        add_stats(3, 32'd5, 8'h01);
        add_op(CMD_PLACE, 3);
        add_op(CMD_BALANCE, 0);          // overloaded CPU owns no IRQ
        add_load(0, 9500);
        add_load(1, 100);
        add_op(CMD_BALANCE, 0);
        add_op(CMD_BALANCE, 0);
        add_stats(0, 32'd0, 8'hFF);      // stats keep owner and weight
        add_op(CMD_BALANCE, 0);
        add_load(0, 0);                  // zero load is under the threshold
        add_op(CMD_BALANCE, 0);
        drain();

        thr_set   = '{14'd9000, 14'd10000, 14'd0, 14'd5000, 14'd1, 14'd16383, 14'd7000, 14'd3000};
        strat_set = '{STRAT_MAX, STRAT_MIN, STRAT_RAND, 2'd3, STRAT_RAND, STRAT_MAX,
                      STRAT_RAND, STRAT_MIN};
        seed_set  = '{16'd1, 16'd65535, 16'd0, 16'hACE1, 16'd1, 16'd44257, 16'h8000, 16'd3};
        phase = 0;
        while (n_items < TARGET_ITEMS)
        begin
            write_reg(CFG_THRESHOLD, phase < 8 ? thr_set[phase] : $urandom_range(0, 10000));
            write_reg(CFG_STRATEGY, phase < 8 ? strat_set[phase] : $urandom_range(0, 3));
            write_reg(CFG_SEED, phase < 8 ? seed_set[phase] : $urandom_range(1, 65535));
            for (int k = 0; k < 5; k++)
                scenario();
            drain();
            phase++;
        end
        repeat (50) @(posedge clk);

        $display("ran %0d commands over %0d register settings: %0d balance steps, %0d moves",
                 n_items, phase + 1, n_balance, n_moves);
        if (errors == 0 && move_q.size() == 0)
            $display("testbench: clean");
        else
        begin
            $display("%0d mismatches, %0d results missing", errors, move_q.size());
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
